>>> src/tcce_pkg.sv
// shared constants, field widths and request codes for the text console engine
// no dependencies; used by the top level and its port checker
`default_nettype none

package tcce_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int MOVE_N  = (ROWS - 1) * COLUMNS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);

    // stream field widths
    localparam int REQ_FW  = 2;
    localparam int CHAR_FW = 8;
    localparam int ROW_FW  = 5;
    localparam int COL_FW  = 7;
    localparam int IDX_FW  = 11;
    localparam int CELL_W  = 16;
    localparam int COLOR_W = 8;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // request codes
    localparam logic [REQ_FW-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_FW-1:0] REQ_SETCUR = 2'd1;
    localparam logic [REQ_FW-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_FW-1:0] REQ_READ  = 2'd3;

    // control characters
    localparam logic [CHAR_FW-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_FW-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_FW-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_FW-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_FW-1:0] CH_SPACE = 8'h20;

    localparam int TAB_STEP = 8;

    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(32'(row) * COLUMNS + 32'(col));
    endfunction

endpackage

`default_nettype wire

>>> src/text_console_character_engine.sv
// put character and set cursor go from the input beat through EXEC to DONE, read cell through EXEC, RDWAIT
// and DONE; clear screen adds a BLANK pass over all cells, a put character that scrolls a SCROLL pass
// and a BLANK pass of the last row, both bound by the single write port of the cell memory (one cell a cycle)
// requests are taken one at a time, only in IDLE; a new beat is taken while a result waits
// reset: cursor to 0,0 and colour to 0x07, then a clearing pass writes all CELLS (2000) cells blank
// while s_axis_tready stays low; config writes are taken throughout
`default_nettype none

module text_console_character_engine (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // config: text colour byte
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tcce_pkg::COLOR_W-1:0]   i_cfg_data,
    // request stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] char_code, [12:8] target_row, [19:13] target_column, [23:20] zero
    input  wire logic [tcce_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] req_type
    input  wire logic [tcce_pkg::REQ_FW-1:0]    s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [4:0] cursor_row_out, [11:5] cursor_column_out, [22:12] cursor_index,
    // [23] scrolled, [39:24] cell_value
    output logic [tcce_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_SCROLL = 3'd4;
    localparam logic [2:0] ST_BLANK  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    localparam int ROW_W  = tcce_pkg::ROW_W;
    localparam int COL_W  = tcce_pkg::COL_W;
    localparam int ADDR_W = tcce_pkg::ADDR_W;

    logic [2:0]                      r_state, n_state;
    logic [ADDR_W-1:0]               r_cnt, n_cnt;
    logic [ROW_W-1:0]                r_row, n_row;
    logic [COL_W-1:0]                r_col, n_col;
    logic [tcce_pkg::COLOR_W-1:0]    r_color;
    logic                            r_scr, n_scr;
    logic [tcce_pkg::CELL_W-1:0]     r_cell, n_cell;
    logic                            r_mv_valid, n_mv_valid;
    logic [ADDR_W-1:0]               r_mv_addr, n_mv_addr;

    logic [tcce_pkg::REQ_FW-1:0]     r_req;
    logic [tcce_pkg::CHAR_FW-1:0]    r_ch;
    logic [tcce_pkg::ROW_FW-1:0]     r_trow;
    logic [tcce_pkg::COL_FW-1:0]     r_tcol;

    logic                            r_m_valid;
    logic [tcce_pkg::M_TDATA_W-1:0]  r_m_data;

    // cell memory
    logic [tcce_pkg::CELL_W-1:0]     mem [tcce_pkg::CELLS];
    logic [tcce_pkg::CELL_W-1:0]     r_rd_data;
    logic                            mem_we;
    logic [ADDR_W-1:0]               mem_waddr;
    logic [ADDR_W-1:0]               mem_raddr;
    logic [tcce_pkg::CELL_W-1:0]     mem_wdata;

    logic                            in_beat;
    logic                            out_load;
    logic [ROW_W-1:0]                t_row;
    logic [COL_W-1:0]                t_col;

    // put character results
    logic [COL_W:0]                  pc_col;
    logic [ROW_W:0]                  pc_row;
    logic                            pc_we;
    logic [ADDR_W-1:0]               pc_addr;
    logic [tcce_pkg::CELL_W-1:0]     pc_data;
    logic                            pc_scroll;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == ST_DONE) && (!r_m_valid || m_axis_tready);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // saturate targets to the screen
    assign t_row = (32'(r_trow) >= tcce_pkg::ROWS) ? ROW_W'(tcce_pkg::ROWS - 1)
                                                   : ROW_W'(r_trow);
    assign t_col = (32'(r_tcol) >= tcce_pkg::COLUMNS) ? COL_W'(tcce_pkg::COLUMNS - 1)
                                                      : COL_W'(r_tcol);

    always_comb begin
        pc_col  = {1'b0, r_col};
        pc_row  = {1'b0, r_row};
        pc_we   = 1'b0;
        pc_addr = tcce_pkg::cell_addr(r_row, r_col);
        pc_data = {r_color, r_ch};
        case (r_ch)
            tcce_pkg::CH_BS: begin
                if (r_col == '0) begin
                    // top-left stays put
                    if (r_row != '0) begin
                        pc_row = pc_row - 1'b1;
                        pc_col = (COL_W + 1)'(tcce_pkg::COLUMNS - 1);
                    end
                end else begin
                    pc_col = pc_col - 1'b1;
                end
                pc_we   = 1'b1;
                pc_addr = tcce_pkg::cell_addr(pc_row[ROW_W-1:0], pc_col[COL_W-1:0]);
                pc_data = {r_color, tcce_pkg::CH_SPACE};
            end
            tcce_pkg::CH_TAB: begin
                pc_col = (pc_col + (COL_W + 1)'(tcce_pkg::TAB_STEP))
                         & ~(COL_W + 1)'(tcce_pkg::TAB_STEP - 1);
            end
            tcce_pkg::CH_CR: begin
                pc_col = '0;
            end
            tcce_pkg::CH_LF: begin
                pc_col = '0;
                pc_row = pc_row + 1'b1;
            end
            default: begin
                pc_we  = 1'b1;
                pc_col = pc_col + 1'b1;
            end
        endcase
        if (pc_col >= (COL_W + 1)'(tcce_pkg::COLUMNS)) begin
            pc_col = '0;
            pc_row = pc_row + 1'b1;
        end
        pc_scroll = (pc_row >= (ROW_W + 1)'(tcce_pkg::ROWS));
        if (pc_scroll) begin
            pc_row = (ROW_W + 1)'(tcce_pkg::ROWS - 1);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_row      = r_row;
        n_col      = r_col;
        n_scr      = r_scr;
        n_cell     = r_cell;
        n_mv_valid = 1'b0;
        n_mv_addr  = r_mv_addr;
        mem_raddr  = tcce_pkg::cell_addr(t_row, t_col);
        mem_we     = 1'b0;
        mem_waddr  = r_cnt;
        mem_wdata  = {r_color, tcce_pkg::CH_SPACE};

        case (r_state)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {tcce_pkg::RESET_COLOR, tcce_pkg::CH_SPACE};
                if (r_cnt == ADDR_W'(tcce_pkg::CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (in_beat) begin
                    n_scr   = 1'b0;
                    n_cell  = '0;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_req)
                    tcce_pkg::REQ_PUT: begin
                        mem_we    = pc_we;
                        mem_waddr = pc_addr;
                        mem_wdata = pc_data;
                        n_row     = pc_row[ROW_W-1:0];
                        n_col     = pc_col[COL_W-1:0];
                        n_scr     = pc_scroll;
                        n_cnt     = '0;
                        n_state   = pc_scroll ? ST_SCROLL : ST_DONE;
                    end
                    tcce_pkg::REQ_SETCUR: begin
                        n_row   = t_row;
                        n_col   = t_col;
                        n_state = ST_DONE;
                    end
                    tcce_pkg::REQ_CLEAR: begin
                        n_row   = '0;
                        n_col   = '0;
                        n_cnt   = '0;
                        n_state = ST_BLANK;
                    end
                    default: begin
                        n_state = ST_RDWAIT;
                    end
                endcase
            end
            ST_RDWAIT: begin
                n_cell  = r_rd_data;
                n_state = ST_DONE;
            end
            ST_SCROLL: begin
                // read one row down, write it back in the following cycle
                if (r_cnt == ADDR_W'(tcce_pkg::MOVE_N)) begin
                    n_state = ST_BLANK;
                end else begin
                    mem_raddr  = r_cnt + ADDR_W'(tcce_pkg::COLUMNS);
                    n_mv_valid = 1'b1;
                    n_mv_addr  = r_cnt;
                    n_cnt      = r_cnt + 1'b1;
                end
            end
            ST_BLANK: begin
                mem_we = 1'b1;
                if (r_cnt == ADDR_W'(tcce_pkg::CELLS - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // pending row move has the write port
        if (r_mv_valid) begin
            mem_we    = 1'b1;
            mem_waddr = r_mv_addr;
            mem_wdata = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_cnt      <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_color    <= tcce_pkg::RESET_COLOR;
            r_mv_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_row      <= n_row;
            r_col      <= n_col;
            r_mv_valid <= n_mv_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_color <= i_cfg_data;
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scr     <= n_scr;
        r_cell    <= n_cell;
        r_mv_addr <= n_mv_addr;
        if (in_beat) begin
            r_req  <= s_axis_tuser;
            r_ch   <= s_axis_tdata[7:0];
            r_trow <= s_axis_tdata[12:8];
            r_tcol <= s_axis_tdata[19:13];
        end
        if (out_load) begin
            r_m_data <= {r_cell, r_scr,
                         tcce_pkg::IDX_FW'(tcce_pkg::cell_addr(r_row, r_col)),
                         tcce_pkg::COL_FW'(r_col), tcce_pkg::ROW_FW'(r_row)};
        end
    end

endmodule

`default_nettype wire

>>> src/tcce_checker.sv
// port-level checks for the text console engine, bound to the top level
// depends on tcce_pkg for the screen geometry
`default_nettype none

module tcce_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [tcce_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic [4:0]  c_row;
    logic [6:0]  c_col;
    logic [10:0] c_idx;
    logic        c_scr;

    assign c_row = m_axis_tdata[4:0];
    assign c_col = m_axis_tdata[11:5];
    assign c_idx = m_axis_tdata[22:12];
    assign c_scr = m_axis_tdata[23];

    // clearing pass blocks requests right after reset
    a_init_blocks: assert property (@(posedge i_clk) !i_rst_n |=> !s_axis_tready)
        else $error("request taken during clearing pass");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(c_idx) == 32'(c_row) * tcce_pkg::COLUMNS + 32'(c_col))
        else $error("cursor index does not match row and column");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(c_row) < tcce_pkg::ROWS && 32'(c_col) < tcce_pkg::COLUMNS)
        else $error("cursor off screen");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && c_scr |-> 32'(c_row) == tcce_pkg::ROWS - 1)
        else $error("scroll left cursor above last row");

endmodule

bind text_console_character_engine tcce_checker u_tcce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
